FILE: rtl/core/min_tracking_stack_core_assert.svh
// Assertion macros shared by the min stack checker.
`ifndef MIN_TRACKING_STACK_CORE_ASSERT_SVH
`define MIN_TRACKING_STACK_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MSTK_AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("min stack assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MSTK_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("min stack assertion failed");

`endif

FILE: rtl/core/min_stk_pkg.sv
// Shared types and constants for the min tracking stack.
package min_stk_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_POP  = 2'd1;
	localparam logic [1:0] KIND_PEEK = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]                    kind;
		logic signed [VALUE_WIDTH-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] top_value;
		logic signed [VALUE_WIDTH-1:0] min_value;
		logic [CNT_W-1:0]              occupancy;
		logic                          is_empty;
		status_t                       status;
	} res_t;

	// Controller to memory: one write port and one read port per cycle.
	typedef struct packed {
		logic                          we;
		logic [ADDR_W-1:0]             waddr;
		logic signed [VALUE_WIDTH-1:0] wvalue;
		logic signed [VALUE_WIDTH-1:0] wmin;
		logic [ADDR_W-1:0]             raddr;
	} mem_req_t;

	// Registered read data, valid the cycle after raddr was presented.
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic signed [VALUE_WIDTH-1:0] min;
	} mem_rd_t;

endpackage

FILE: rtl/core/min_stk_ram.sv
// Value and running-minimum stores, one write and one registered read per cycle.
module min_stk_ram (
	input  logic                  clk,
	input  min_stk_pkg::mem_req_t mreq,
	output min_stk_pkg::mem_rd_t  mrd
);
	import min_stk_pkg::*;

	logic signed [VALUE_WIDTH-1:0] val_mem [STACK_DEPTH];
	logic signed [VALUE_WIDTH-1:0] min_mem [STACK_DEPTH];
	mem_rd_t                       rd_q;

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			val_mem[mreq.waddr] <= mreq.wvalue;
			min_mem[mreq.waddr] <= mreq.wmin;
		end
		rd_q.value <= val_mem[mreq.raddr];
		rd_q.min   <= min_mem[mreq.raddr];
	end

	assign mrd = rd_q;

endmodule

FILE: rtl/core/min_stk_ctrl.sv
// Request decode, top-of-stack cache, entry count and result register.
module min_stk_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  min_stk_pkg::req_t     cmd,
	output logic                  done,
	output min_stk_pkg::res_t     result,
	output min_stk_pkg::mem_req_t mreq,
	input  min_stk_pkg::mem_rd_t  mrd
);
	import min_stk_pkg::*;

	typedef enum logic {IDLE, LOAD} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              count_q;
	logic signed [VALUE_WIDTH-1:0] top_q;
	logic signed [VALUE_WIDTH-1:0] min_q;
	logic                          done_q;
	res_t                          res_q;

	logic                          accept;
	logic                          full;
	logic                          empty;
	logic signed [VALUE_WIDTH-1:0] new_min;
	logic [CNT_W-1:0]              count_inc;
	logic [CNT_W-1:0]              count_dec;
	logic [CNT_W-1:0]              below_top;

	assign accept    = start && (state_q == IDLE);
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign empty     = (count_q == '0);
	assign count_inc = count_q + CNT_W'(1);
	assign count_dec = count_q - CNT_W'(1);
	assign below_top = count_q - CNT_W'(2);
	assign new_min   = (empty || (cmd.push_value < min_q)) ? cmd.push_value : min_q;

	always_comb begin
		mreq.we     = accept && (cmd.kind == KIND_PUSH) && !full;
		mreq.waddr  = count_q[ADDR_W-1:0];
		mreq.wvalue = cmd.push_value;
		mreq.wmin   = new_min;
		// entry under the current top; used only by a pop that leaves entries
		mreq.raddr  = below_top[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			top_q   <= '0;
			min_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (accept) begin
						res_q.status    <= ST_OK;
						res_q.top_value <= empty ? '0 : top_q;
						res_q.min_value <= empty ? '0 : min_q;
						res_q.occupancy <= count_q;
						res_q.is_empty  <= empty;
						done_q          <= 1'b1;
						case (cmd.kind)
							KIND_PUSH: begin
								if (full) begin
									res_q.status <= ST_OVERFLOW;
								end else begin
									count_q         <= count_inc;
									top_q           <= cmd.push_value;
									min_q           <= new_min;
									res_q.top_value <= cmd.push_value;
									res_q.min_value <= new_min;
									res_q.occupancy <= count_inc;
									res_q.is_empty  <= 1'b0;
								end
							end
							KIND_POP: begin
								if (empty) begin
									res_q.status <= ST_UNDERFLOW;
								end else if (count_q == CNT_W'(1)) begin
									count_q         <= '0;
									res_q.top_value <= '0;
									res_q.min_value <= '0;
									res_q.occupancy <= '0;
									res_q.is_empty  <= 1'b1;
								end else begin
									// new top comes back from memory next cycle
									count_q <= count_dec;
									done_q  <= 1'b0;
									state_q <= LOAD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				LOAD: begin
					top_q           <= mrd.value;
					min_q           <= mrd.min;
					res_q.top_value <= mrd.value;
					res_q.min_value <= mrd.min;
					res_q.occupancy <= count_q;
					res_q.is_empty  <= 1'b0;
					res_q.status    <= ST_OK;
					done_q          <= 1'b1;
					state_q         <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: rtl/core/min_tracking_stack_core.sv
// Push, peek, spare-code, error and emptying-pop results strobe done in the cycle after the request.
// A pop that leaves entries passes through the LOAD state: the new top and minimum are
// read back from the stores' registered read port while busy is high.
// One request per cycle is accepted while busy is low; such pops hold busy high meanwhile.
// Reset clears the entry count, state and controller registers; the stores are not cleared.
// Results cannot be stalled: each is valid for the single cycle done is high.
module min_tracking_stack_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  min_stk_pkg::req_t cmd,
	output logic              done,
	output min_stk_pkg::res_t result
);
	import min_stk_pkg::*;

	mem_req_t mreq;
	mem_rd_t  mrd;

	min_stk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result),
		.mreq   (mreq),
		.mrd    (mrd)
	);

	min_stk_ram u_ram (
		.clk  (clk),
		.mreq (mreq),
		.mrd  (mrd)
	);

endmodule

FILE: rtl/core/min_stk_chk.sv
// Port-level checker for the min tracking stack, bound to the top level.
`include "min_tracking_stack_core_assert.svh"

module min_stk_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input min_stk_pkg::req_t cmd,
	input logic              done,
	input min_stk_pkg::res_t result
);
	import min_stk_pkg::*;

	// a refill ends with a result and busy low in the next cycle
	`MSTK_AST_NEXT(a_busy_one_cycle, busy, done && !busy)
	// busy is entered only through an accepted request
	`MSTK_AST_IMPL(a_busy_after_req, busy, $past(start && !busy))
	`MSTK_AST_IMPL(a_empty_zeros, done && result.is_empty, (result.occupancy == '0) && (result.top_value == '0) && (result.min_value == '0))
	`MSTK_AST_IMPL(a_empty_flag, done, result.is_empty == (result.occupancy == '0))
	`MSTK_AST_IMPL(a_overflow_push, done && (result.status == ST_OVERFLOW), (result.occupancy == CNT_W'(STACK_DEPTH)) && $past(start && !busy && (cmd.kind == KIND_PUSH)))

endmodule

bind min_tracking_stack_core min_stk_chk u_chk (.*);

FILE: tb/sv/min_stack_checker.sv
// Checker for the min tracking stack: predicts each result and compares it with the block.
module min_stack_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  min_stk_pkg::req_t cmd,
	input  logic              done,
	input  min_stk_pkg::res_t result,
	output int                failures,
	output int                pending,
	output int                checked,
	output int                overflows,
	output int                underflows
);
	import min_stk_pkg::*;

	// Shadow copy of the block's state
	logic signed [VALUE_WIDTH-1:0] shadow_vals [STACK_DEPTH];
	logic signed [VALUE_WIDTH-1:0] shadow_mins [STACK_DEPTH];
	logic [CNT_W-1:0]              shadow_held;

	res_t expected_q[$];
	int   err_count;
	int   seen_count;
	int   ovf_count;
	int   unf_count;

	// Applies one request to the shadow stack and returns the result it should produce.
	function automatic res_t apply_request(req_t r);
		res_t             o;
		logic [CNT_W-1:0] below;
		o = '0;
		o.status = ST_OK;
		below = shadow_held - CNT_W'(1);
		case (r.kind)
			KIND_PUSH: begin
				if (shadow_held == CNT_W'(STACK_DEPTH)) begin
					o.status = ST_OVERFLOW;
				end else begin
					shadow_vals[shadow_held[ADDR_W-1:0]] = r.push_value;
					// equal values keep the existing minimum
					if (shadow_held == '0 ||
						r.push_value < shadow_mins[below[ADDR_W-1:0]])
						shadow_mins[shadow_held[ADDR_W-1:0]] = r.push_value;
					else
						shadow_mins[shadow_held[ADDR_W-1:0]] =
							shadow_mins[below[ADDR_W-1:0]];
					shadow_held = shadow_held + CNT_W'(1);
				end
			end
			KIND_POP: begin
				if (shadow_held == '0)
					o.status = ST_UNDERFLOW;
				else
					shadow_held = shadow_held - CNT_W'(1);
			end
			default: ; // peek and the spare code leave the stack alone
		endcase
		below = shadow_held - CNT_W'(1);
		if (shadow_held != '0) begin
			o.top_value = shadow_vals[below[ADDR_W-1:0]];
			o.min_value = shadow_mins[below[ADDR_W-1:0]];
		end
		o.occupancy = shadow_held;
		o.is_empty  = (shadow_held == '0);
		return o;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch in %s: expected %h actual %h", $time, name, want, got);
			err_count++;
		end
	endtask

	initial begin
		err_count  = 0;
		seen_count = 0;
		ovf_count  = 0;
		unf_count  = 0;
		failures   = 0;
		pending    = 0;
		checked    = 0;
		overflows  = 0;
		underflows = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			shadow_held = '0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (start && !busy)
				expected_q.push_back(apply_request(cmd));
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("%0t unexpected result: expected none actual %h", $time, result);
					err_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("top_value", want.top_value, result.top_value);
					check_field("min_value", want.min_value, result.min_value);
					check_field("occupancy", 32'(want.occupancy), 32'(result.occupancy));
					check_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
					check_field("status", 32'(want.status), 32'(result.status));
					seen_count++;
					if (want.status == ST_OVERFLOW)
						ovf_count++;
					if (want.status == ST_UNDERFLOW)
						unf_count++;
				end
			end
			pending    <= expected_q.size();
			failures   <= err_count;
			checked    <= seen_count;
			overflows  <= ovf_count;
			underflows <= unf_count;
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// Top of the min tracking stack testbench: clock, reset, requests and the verdict.
module testbench;
	import min_stk_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1600;
	localparam int STALL_LIMIT  = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t cmd;
	logic done;
	res_t result;

	int failures;
	int pending;
	int checked;
	int overflows;
	int underflows;

	int n_push;
	int n_pop;
	int n_peek;
	int idle_cycles;

	logic signed [VALUE_WIDTH-1:0] recent_value;

	min_tracking_stack_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	min_stack_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.result     (result),
		.failures   (failures),
		.pending    (pending),
		.checked    (checked),
		.overflows  (overflows),
		.underflows (underflows)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watchdog: too long with neither a request nor a result taken
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic req_t mk(input logic [1:0] kind, input logic [31:0] value);
		req_t r;
		r.kind       = kind;
		r.push_value = value;
		return r;
	endfunction

	// Mix of extremes, small values (many ties), repeats of the last push and full-range values
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0;
			3:       return 32'hffff_ffff;
			4, 5:    return 32'($urandom_range(0, 15)) - 32'd8;
			6:       return recent_value;
			default: return $urandom();
		endcase
	endfunction

	task automatic send(input req_t r, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 99) < 14) begin
			start <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= r;
		case (r.kind)
			KIND_PUSH: n_push++;
			KIND_POP:  n_pop++;
			default:   n_peek++;
		endcase
		if (r.kind == KIND_PUSH)
			recent_value = r.push_value;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		req_t directed_q[$];
		req_t r;
		int   push_pct;
		int   phase_left;
		int   roll;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		idle_cycles  = 0;
		n_push       = 0;
		n_pop        = 0;
		n_peek       = 0;
		recent_value = '0;
		push_pct     = 50;
		phase_left   = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack: underflow, peek, spare code
		directed_q.push_back(mk(KIND_POP, 32'h1234_5678));
		directed_q.push_back(mk(KIND_PEEK, 32'hffff_ffff));
		directed_q.push_back(mk(KIND_SPARE, 32'h0));
		// extremes, then a tie with the minimum
		directed_q.push_back(mk(KIND_PUSH, 32'h0));
		directed_q.push_back(mk(KIND_PUSH, 32'h7fff_ffff));
		directed_q.push_back(mk(KIND_PUSH, 32'h8000_0000));
		directed_q.push_back(mk(KIND_PUSH, 32'h8000_0000));
		directed_q.push_back(mk(KIND_PUSH, 32'd5));
		directed_q.push_back(mk(KIND_PEEK, 32'h5555_aaaa));
		directed_q.push_back(mk(KIND_SPARE, 32'haaaa_5555));
		// unwind to empty, minimum must follow back up
		repeat (5) directed_q.push_back(mk(KIND_POP, 32'h0));
		directed_q.push_back(mk(KIND_POP, 32'hffff_ffff));
		directed_q.push_back(mk(KIND_PUSH, 32'hffff_ffff));
		directed_q.push_back(mk(KIND_PUSH, 32'hffff_ffff));
		directed_q.push_back(mk(KIND_PUSH, 32'd1));
		repeat (3) directed_q.push_back(mk(KIND_POP, 32'h0));
		foreach (directed_q[k])
			send(directed_q[k], 1'b1);

		// Phases lean toward pushes (to hit full) or pops (to hit empty)
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
					0:       push_pct = 90;
					1:       push_pct = 55;
					default: push_pct = 15;
				endcase
				phase_left = $urandom_range(80, 160);
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			if (roll < push_pct) begin
				r = mk(KIND_PUSH, pick_value());
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 75)
					r = mk(KIND_POP, $urandom());
				else if (roll < 95)
					r = mk(KIND_PEEK, $urandom());
				else
					r = mk(KIND_SPARE, $urandom());
			end
			// one long stretch at full rate
			send(r, !(i >= 700 && i < 1000));
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d pushes, %0d pops, %0d peeks; %0d results checked.",
			n_push, n_pop, n_peek, checked);
		$display("Overflow results: %0d, underflow results: %0d.", overflows, underflows);
		if (failures == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
